// File: rtl/core/spf_pkg.sv
`default_nettype none

package spf_pkg;

    localparam int VAL_W         = 16;
    localparam int EXP_W         = 5;
    localparam int RES_W         = 6;
    localparam int K_W           = 7;
    localparam int K_MAX         = 64;
    localparam int K_RESET       = 2;
    localparam int TABLE_CAP     = 65536;
    localparam int MAX_VALUE_DEF = 65536;
    localparam int OUT_TDATA_W   = 40;
    localparam int DIV_CNT_W     = $clog2(VAL_W + 1);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_SQ,
        ST_PRD,
        ST_PCHK,
        ST_JRD,
        ST_JCHK,
        ST_IDLE,
        ST_FRD,
        ST_FCHK,
        ST_FNEWP,
        ST_DSTART,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] dividend;
        logic [VAL_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/spf_ram.sv
`default_nettype none

module spf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/spf_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module spf_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire spf_pkg::div_req_t req,
    output spf_pkg::div_rsp_t      rsp
);

    localparam int VW = spf_pkg::VAL_W;
    localparam int CW = spf_pkg::DIV_CNT_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] acc_reg, acc_next;
    logic [VW-1:0] q_reg, q_next;
    logic [VW-1:0] div_reg, div_next;
    logic [VW:0]   trial;

    always_comb
    begin
        trial     = {acc_reg, q_reg[VW-1]} - {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        q_next    = q_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(VW);
            acc_next  = '0;
            q_next    = req.dividend;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[VW])
            begin
                acc_next = trial[VW-1:0];
                q_next   = {q_reg[VW-2:0], 1'b1};
            end
            else
            begin
                acc_next = {acc_reg[VW-2:0], q_reg[VW-1]};
                q_next   = {q_reg[VW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        q_reg   <= q_next;
        div_reg <= div_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

`default_nettype wire

// File: rtl/core/spf_sieve_factorizer.sv
// Startup: after reset the table is filled and then sieved. Not ready until done.
// Per item: each prime factor, counted with multiplicity, takes a table lookup and a
//   division in the divider; each result is then emitted.
// One item at a time; the next item is taken while the last result still waits.
// rst_n is asynchronous, active low; power_k resets to 2.
`default_nettype none

module spf_sieve_factorizer #(
    parameter int MAX_VALUE = spf_pkg::MAX_VALUE_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [spf_pkg::K_W-1:0]         cfg_wr_data,   // power_k
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [spf_pkg::VAL_W-1:0]       s_axis_tdata,  // value_in
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // prime[15:0], exponent[20:16], residue[26:21], complement[32:27], zero pad
    output logic [spf_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast
);

    localparam int TABLE_SIZE = (MAX_VALUE < spf_pkg::TABLE_CAP) ? MAX_VALUE
                                                                 : spf_pkg::TABLE_CAP;
    localparam int AW    = $clog2(TABLE_SIZE);
    localparam int SQ_W  = 2 * AW;
    localparam int JW    = AW + 1;
    localparam int VW    = spf_pkg::VAL_W;
    localparam int VX_W  = spf_pkg::VAL_W + 1;
    localparam int EW    = spf_pkg::EXP_W;
    localparam int RW    = spf_pkg::RES_W;
    localparam int KW    = spf_pkg::K_W;
    localparam int PAD_W = spf_pkg::OUT_TDATA_W - (VW + EW + 2 * RW);

    spf_pkg::state_t state_reg, state_next;

    logic [KW-1:0]   power_k_reg;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [AW-1:0]   i_reg, i_next;
    logic [SQ_W-1:0] sq_reg, sq_next;
    logic [JW-1:0]   j_reg, j_next;
    logic [VW-1:0]   rem_reg, rem_next;
    logic [VW-1:0]   p_reg, p_next;
    logic [VW-1:0]   spf_reg, spf_next;
    logic [EW-1:0]   exp_reg, exp_next;
    logic [RW-1:0]   res_reg, res_next;
    logic            last_reg, last_next;
    logic [VW-1:0]   out_prime_reg, out_prime_next;
    logic [EW-1:0]   out_exp_reg, out_exp_next;
    logic [RW-1:0]   out_res_reg, out_res_next;
    logic [RW-1:0]   out_comp_reg, out_comp_next;
    logic            out_last_reg, out_last_next;
    logic            out_valid_reg, out_valid_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [VW-1:0]   ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [VW-1:0]   ram_rdata;

    spf_pkg::div_req_t div_req;
    spf_pkg::div_rsp_t div_rsp;

    logic [KW-1:0]   kk;
    logic [KW-1:0]   res_inc;
    logic [RW-1:0]   res_wrap;
    logic [RW-1:0]   comp;
    logic            emit_ok;
    logic            in_bad;

    spf_ram #(
        .WIDTH (VW),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    spf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // effective k, clamped to 1..64
    always_comb
    begin
        if (power_k_reg == '0)
        begin
            kk = KW'(1);
        end
        else if (power_k_reg > KW'(spf_pkg::K_MAX))
        begin
            kk = KW'(spf_pkg::K_MAX);
        end
        else
        begin
            kk = power_k_reg;
        end
    end

    // residue is tracked alongside the exponent, wrapping at k
    assign res_inc  = KW'(res_reg) + KW'(1);
    assign res_wrap = (res_inc == kk) ? '0 : RW'(res_inc);
    assign comp     = (res_reg == '0) ? '0 : RW'(kk - KW'(res_reg));
    assign emit_ok  = !out_valid_reg || m_axis_tready;
    assign in_bad   = (s_axis_tdata <= VW'(1)) ||
                      (VX_W'(s_axis_tdata) >= VX_W'(TABLE_SIZE));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spf_pkg::ST_INIT:
            begin
                if (idx_reg == AW'(TABLE_SIZE - 1))
                begin
                    state_next = spf_pkg::ST_SQ;
                end
            end
            spf_pkg::ST_SQ:
            begin
                state_next = spf_pkg::ST_PRD;
            end
            spf_pkg::ST_PRD:
            begin
                if (sq_reg >= SQ_W'(TABLE_SIZE))
                begin
                    state_next = spf_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = spf_pkg::ST_PCHK;
                end
            end
            spf_pkg::ST_PCHK:
            begin
                if (ram_rdata == VW'(i_reg))
                begin
                    state_next = spf_pkg::ST_JRD;
                end
                else
                begin
                    state_next = spf_pkg::ST_SQ;
                end
            end
            spf_pkg::ST_JRD:
            begin
                if (j_reg >= JW'(TABLE_SIZE))
                begin
                    state_next = spf_pkg::ST_SQ;
                end
                else
                begin
                    state_next = spf_pkg::ST_JCHK;
                end
            end
            spf_pkg::ST_JCHK:
            begin
                state_next = spf_pkg::ST_JRD;
            end
            spf_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = in_bad ? spf_pkg::ST_EMIT : spf_pkg::ST_FRD;
                end
            end
            spf_pkg::ST_FRD:
            begin
                state_next = spf_pkg::ST_FCHK;
            end
            spf_pkg::ST_FCHK:
            begin
                if (ram_rdata == p_reg || exp_reg == '0)
                begin
                    state_next = spf_pkg::ST_DSTART;
                end
                else
                begin
                    state_next = spf_pkg::ST_EMIT;
                end
            end
            spf_pkg::ST_FNEWP:
            begin
                state_next = spf_pkg::ST_DSTART;
            end
            spf_pkg::ST_DSTART:
            begin
                state_next = spf_pkg::ST_DIV;
            end
            spf_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient <= VW'(1))
                    begin
                        state_next = spf_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = spf_pkg::ST_FRD;
                    end
                end
            end
            spf_pkg::ST_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = last_reg ? spf_pkg::ST_IDLE : spf_pkg::ST_FNEWP;
                end
            end
            default:
            begin
                state_next = spf_pkg::ST_INIT;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        idx_next         = idx_reg;
        i_next           = i_reg;
        sq_next          = sq_reg;
        j_next           = j_reg;
        rem_next         = rem_reg;
        p_next           = p_reg;
        spf_next         = spf_reg;
        exp_next         = exp_reg;
        res_next         = res_reg;
        last_next        = last_reg;
        out_prime_next   = out_prime_reg;
        out_exp_next     = out_exp_reg;
        out_res_next     = out_res_reg;
        out_comp_next    = out_comp_reg;
        out_last_next    = out_last_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        ram_we           = 1'b0;
        ram_waddr        = idx_reg;
        ram_wdata        = VW'(idx_reg);
        ram_raddr        = rem_reg[AW-1:0];
        div_req.start    = 1'b0;
        div_req.dividend = rem_reg;
        div_req.divisor  = p_reg;
        s_axis_tready    = 1'b0;

        case (state_reg)
            spf_pkg::ST_INIT:
            begin
                // spf(i) = i, except 2 for even i >= 2
                ram_we   = 1'b1;
                if (!idx_reg[0] && idx_reg >= AW'(2))
                begin
                    ram_wdata = VW'(2);
                end
                idx_next = idx_reg + AW'(1);
                i_next   = AW'(3);
            end
            spf_pkg::ST_SQ:
            begin
                sq_next = SQ_W'(i_reg) * SQ_W'(i_reg);
            end
            spf_pkg::ST_PRD:
            begin
                ram_raddr = i_reg;
            end
            spf_pkg::ST_PCHK:
            begin
                if (ram_rdata == VW'(i_reg))
                begin
                    j_next = JW'(sq_reg);
                end
                else
                begin
                    i_next = i_reg + AW'(2);
                end
            end
            spf_pkg::ST_JRD:
            begin
                ram_raddr = j_reg[AW-1:0];
                if (j_reg >= JW'(TABLE_SIZE))
                begin
                    i_next = i_reg + AW'(2);
                end
            end
            spf_pkg::ST_JCHK:
            begin
                // only unmarked entries take the prime
                ram_waddr = j_reg[AW-1:0];
                ram_wdata = VW'(i_reg);
                ram_we    = (ram_rdata == VW'(j_reg[AW-1:0]));
                j_next    = j_reg + JW'(i_reg);
            end
            spf_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                p_next        = '0;
                exp_next      = '0;
                res_next      = '0;
                last_next     = in_bad;
                rem_next      = s_axis_tdata;
            end
            spf_pkg::ST_FRD:
            begin
                ram_raddr = rem_reg[AW-1:0];
            end
            spf_pkg::ST_FCHK:
            begin
                spf_next = ram_rdata;
                if (ram_rdata != p_reg && exp_reg == '0)
                begin
                    p_next = ram_rdata;
                end
            end
            spf_pkg::ST_FNEWP:
            begin
                p_next   = spf_reg;
                exp_next = '0;
                res_next = '0;
            end
            spf_pkg::ST_DSTART:
            begin
                div_req.start = 1'b1;
            end
            spf_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    rem_next  = div_rsp.quotient;
                    exp_next  = exp_reg + EW'(1);
                    res_next  = res_wrap;
                    last_next = (div_rsp.quotient <= VW'(1));
                end
            end
            spf_pkg::ST_EMIT:
            begin
                if (emit_ok)
                begin
                    out_prime_next = p_reg;
                    out_exp_next   = exp_reg;
                    out_res_next   = res_reg;
                    out_comp_next  = comp;
                    out_last_next  = last_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spf_pkg::ST_INIT;
            power_k_reg   <= KW'(spf_pkg::K_RESET);
            idx_reg       <= '0;
            i_reg         <= '0;
            sq_reg        <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            i_reg         <= i_next;
            sq_reg        <= sq_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                power_k_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        p_reg         <= p_next;
        spf_reg       <= spf_next;
        exp_reg       <= exp_next;
        res_reg       <= res_next;
        last_reg      <= last_next;
        out_prime_reg <= out_prime_next;
        out_exp_reg   <= out_exp_next;
        out_res_reg   <= out_res_next;
        out_comp_reg  <= out_comp_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_comp_reg, out_res_reg, out_exp_reg,
                            out_prime_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/core/spf_chk.sv
`default_nettype none

module spf_chk (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [spf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input wire logic                               m_axis_tlast
);

    // a stalled item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    // no-factor result is all zero and ends the value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[15:0] == 16'd0 |->
            m_axis_tlast && m_axis_tdata[32:16] == 17'd0)
        else $error("prime 0 result not all zero or not last");

    // a real prime has at least one occurrence
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[15:0] != 16'd0 |-> m_axis_tdata[20:16] != 5'd0)
        else $error("prime reported with zero exponent");

    // complement is zero exactly when residue is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[26:21] == 6'd0) == (m_axis_tdata[32:27] == 6'd0)))
        else $error("residue and complement disagree");

endmodule

bind spf_sieve_factorizer spf_chk u_spf_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
